@@ design/trt_pkg.sv @@
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types, constants and the generator step function for the
// combined Tausworthe random table unit.
// ----------------------------------------------------------------------------
package trt_pkg;

	localparam int TableDepthDefault = 512;

	// Depth of the decoupling queue between the front and back parts.
	localparam int QueueDepth = 2;
	localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [31:0] SeedBase       = 32'd12345;
	localparam logic [31:0] SmallSeedLimit = 32'd127;
	localparam logic [31:0] MaskOne        = 32'hFFFF_FFFE;
	localparam logic [31:0] MaskTwo        = 32'hFFFF_FFF8;
	localparam logic [31:0] MaskThree      = 32'hFFFF_FFF0;
	localparam logic [31:0] MaskFour       = 32'hFFFF_FF80;

	typedef enum logic [1:0] {
		REQ_SEED      = 2'd0,
		REQ_PRODUCE   = 2'd1,
		REQ_REFILL    = 2'd2,
		REQ_FAST_READ = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_FILL
	} back_state_t;

	typedef struct packed {
		req_kind_t   req;
		logic [31:0] value;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic [31:0] c4;
	} gen_state_t;

	// One step of all four Tausworthe components.
	function automatic gen_state_t gen_step(input gen_state_t s);
		gen_state_t  n;
		logic [31:0] t;
		t    = ((s.c1 << 6) ^ s.c1) >> 13;
		n.c1 = ((s.c1 & MaskOne) << 18) ^ t;
		t    = ((s.c2 << 2) ^ s.c2) >> 27;
		n.c2 = ((s.c2 & MaskTwo) << 2) ^ t;
		t    = ((s.c3 << 13) ^ s.c3) >> 21;
		n.c3 = ((s.c3 & MaskThree) << 7) ^ t;
		t    = ((s.c4 << 3) ^ s.c4) >> 12;
		n.c4 = ((s.c4 & MaskFour) << 13) ^ t;
		return n;
	endfunction

	function automatic logic [31:0] gen_out(input gen_state_t s);
		return s.c1 ^ s.c2 ^ s.c3 ^ s.c4;
	endfunction

endpackage

@@ design/tausworthe_random_table_unit.sv @@
// ----------------------------------------------------------------------------
// tausworthe_random_table_unit
// A seed or produce word passes through the queue entry and then the result
// register; seed and produce run one word per cycle while the result side is
// not stalled. A fast read adds the BK_READ state for the registered table
// read; a refill holds the back part, writing one table entry per cycle.
// Reset: components 12345, read index zero, table reads zero until the first
// refill; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module tausworthe_random_table_unit
	import trt_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: node number, written whenever cfg_wen is high.
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	// Request words.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // seed_value
	input  logic [1:0]  s_axis_tuser,   // req_type
	// Result words.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // random_value
	output logic [1:0]  m_axis_tuser    // request_echo
);

	// The front part takes each request word, folds the node-dependent base
	// into small seeds and hands the request to the queue. The back part
	// drains the queue one request at a time: seed and produce finish in the
	// pop cycle, a fast read waits in BK_READ for the table read data, and a
	// refill posts its zero result at once and then walks the whole table.
	// The result register sits at the far end so a stalled consumer only
	// backs up the queue, and the front keeps accepting until the queue fills.

	q_stat_t q_stat;
	logic    push;
	q_item_t push_item;
	logic    pop;
	q_item_t head;

	trt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.push          (push),
		.push_item     (push_item)
	);

	trt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// The table lives in the back part; before its first refill every fast
	// read returns zero, which matches a table cleared at reset because a
	// refill always writes every entry before the next read can happen.
	trt_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ design/trt_front.sv @@
// ----------------------------------------------------------------------------
// trt_front
// Accepts request words, applies small-seed mixing and pushes each request
// into the decoupling queue.
// ----------------------------------------------------------------------------
module trt_front
	import trt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // seed_value
	input  logic [1:0]  s_axis_tuser,   // req_type
	input  q_stat_t     q_stat,
	output logic        push,
	output q_item_t     push_item
);

	// 12345 plus the square of the node number, kept ready for seeding.
	logic [31:0] seed_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_base_q <= SeedBase;
		end else if (cfg_wen) begin
			seed_base_q <= SeedBase + 32'(cfg_wdata) * 32'(cfg_wdata);
		end
	end

	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && !q_stat.full;

	always_comb begin
		push_item.req   = req_kind_t'(s_axis_tuser);
		push_item.value = '0;
		if (req_kind_t'(s_axis_tuser) == REQ_SEED) begin
			if (s_axis_tdata < SmallSeedLimit) begin
				push_item.value = s_axis_tdata + seed_base_q;
			end else begin
				push_item.value = s_axis_tdata;
			end
		end
	end

endmodule

@@ design/trt_queue.sv @@
// ----------------------------------------------------------------------------
// trt_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module trt_queue
	import trt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output q_item_t head,
	output q_stat_t q_stat
);

	q_item_t            entry_q [QueueDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   count_q;

	function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCntW'(QueueDepth));
	assign q_stat.empty = (count_q == '0);

endmodule

@@ design/trt_back.sv @@
// ----------------------------------------------------------------------------
// trt_back
// Executes queued requests: holds the generator, the value table, the
// read index and the result register.
// ----------------------------------------------------------------------------
module trt_back
	import trt_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  q_item_t     head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // random_value
	output logic [1:0]  m_axis_tuser    // request_echo
);

	localparam int IdxW = $clog2(TABLE_DEPTH);

	back_state_t      state_q, state_d;
	gen_state_t       comp_q;
	gen_state_t       comp_next;
	logic [31:0]      table_mem [TABLE_DEPTH];
	logic [31:0]      rd_data_q;
	logic [IdxW-1:0]  rd_idx_q;
	logic [IdxW-1:0]  fill_idx_q;
	logic             filled_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;
	req_kind_t        out_kind_q;

	logic             out_free;
	logic             out_load;
	logic [31:0]      out_data_d;
	req_kind_t        out_kind_d;
	logic             gen_adv;
	logic             seed_load;
	logic             rd_en;
	logic             mem_we;
	logic             fill_start;
	logic             idx_adv;

	assign comp_next = gen_step(comp_q);
	assign out_free  = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		out_load   = 1'b0;
		out_data_d = '0;
		out_kind_d = head.req;
		gen_adv    = 1'b0;
		seed_load  = 1'b0;
		rd_en      = 1'b0;
		mem_we     = 1'b0;
		fill_start = 1'b0;
		idx_adv    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty && out_free) begin
					pop = 1'b1;
					case (head.req)
						REQ_SEED: begin
							seed_load = 1'b1;
							out_load  = 1'b1;
						end
						REQ_PRODUCE: begin
							gen_adv    = 1'b1;
							out_load   = 1'b1;
							out_data_d = gen_out(comp_next);
						end
						REQ_REFILL: begin
							out_load   = 1'b1;
							fill_start = 1'b1;
							state_d    = BK_FILL;
						end
						REQ_FAST_READ: begin
							rd_en   = 1'b1;
							state_d = BK_READ;
						end
						default: begin
							state_d = BK_IDLE;
						end
					endcase
				end
			end
			BK_READ: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = REQ_FAST_READ;
					out_data_d = filled_q ? rd_data_q : '0;
					idx_adv    = 1'b1;
					state_d    = BK_IDLE;
				end
			end
			BK_FILL: begin
				gen_adv = 1'b1;
				mem_we  = 1'b1;
				if (fill_idx_q == IdxW'(TABLE_DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[fill_idx_q] <= gen_out(comp_next);
		end
		if (rd_en) begin
			rd_data_q <= table_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_kind_q <= out_kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q      <= '{c1: SeedBase, c2: SeedBase, c3: SeedBase, c4: SeedBase};
			rd_idx_q    <= '0;
			fill_idx_q  <= '0;
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_load) begin
				comp_q <= '{c1: head.value, c2: head.value, c3: head.value,
					c4: head.value};
			end else if (gen_adv) begin
				comp_q <= comp_next;
			end
			if (fill_start) begin
				rd_idx_q   <= '0;
				fill_idx_q <= '0;
				filled_q   <= 1'b1;
			end else begin
				if (mem_we) begin
					fill_idx_q <= fill_idx_q + 1'b1;
				end
				if (idx_adv) begin
					rd_idx_q <= (rd_idx_q == IdxW'(TABLE_DEPTH - 1)) ? '0
						: rd_idx_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

endmodule

@@ design/trt_checker.sv @@
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks on the random table unit, bound to the top level.
// ----------------------------------------------------------------------------
module trt_checker
	import trt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// Words accepted whose result has not yet been delivered.
	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == REQ_SEED || m_axis_tuser == REQ_REFILL)
			|-> m_axis_tdata == '0)
		else $error("seed or refill result is not zero");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> !m_axis_tvalid)
		else $error("result word without an open request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more open requests than the unit can hold");

	// A clock edge seen in reset leaves the result side empty at the next one.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid after a reset cycle");

endmodule

bind tausworthe_random_table_unit trt_checker u_trt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Tausworthe random table unit. Request words are
// sent in random bursts and the result side stalls in changing patterns. A
// scoreboard steps its own copy of the four generator components, the value
// table and the read index for every accepted request word. It then checks
// each result word, in order, against the value it expects.
// ----------------------------------------------------------------------------
module tb_top;
	import trt_pkg::*;

	localparam int TableDepth = TableDepthDefault;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the generator state and the value table, and
	// keeps the queue of result words still owed by the block.
	// ------------------------------------------------------------------------
	class rng_scoreboard;
		typedef struct {
			logic [31:0] value;
			req_kind_t   req;
		} answer_t;

		bit [31:0]   c1, c2, c3, c4;
		bit [31:0]   value_table[TableDepth];
		int unsigned read_idx;
		bit [15:0]   node;
		answer_t     predicted_words[$];
		int          fail_count;

		function new();
			c1 = SeedBase;
			c2 = SeedBase;
			c3 = SeedBase;
			c4 = SeedBase;
			foreach (value_table[i])
				value_table[i] = '0;
			read_idx   = 0;
			node       = '0;
			fail_count = 0;
		endfunction

		// One step of all four components; returns their combined output.
		function bit [31:0] advance();
			bit [31:0] t;
			t  = ((c1 << 6) ^ c1) >> 13;
			c1 = ((c1 & MaskOne) << 18) ^ t;
			t  = ((c2 << 2) ^ c2) >> 27;
			c2 = ((c2 & MaskTwo) << 2) ^ t;
			t  = ((c3 << 13) ^ c3) >> 21;
			c3 = ((c3 & MaskThree) << 7) ^ t;
			t  = ((c4 << 3) ^ c4) >> 12;
			c4 = ((c4 & MaskFour) << 13) ^ t;
			return c1 ^ c2 ^ c3 ^ c4;
		endfunction

		// Applies one accepted request word and queues the result it owes.
		function void note_request(req_kind_t req, bit [31:0] seed);
			answer_t   a;
			bit [31:0] s;
			a.req   = req;
			a.value = '0;
			case (req)
			REQ_SEED: begin
				s = seed;
				// Small seeds get the base plus the node number squared mixed in.
				if (s < SmallSeedLimit)
					s = s + SeedBase + 32'(node) * 32'(node);
				c1 = s;
				c2 = s;
				c3 = s;
				c4 = s;
			end
			REQ_PRODUCE: begin
				a.value = advance();
			end
			REQ_REFILL: begin
				read_idx = 0;
				foreach (value_table[i])
					value_table[i] = advance();
			end
			default: begin
				a.value  = value_table[read_idx];
				read_idx = (read_idx + 1 >= TableDepth) ? 0 : read_idx + 1;
			end
			endcase
			predicted_words.push_back(a);
		endfunction

		function void report(string msg);
			if (fail_count < 100)
				$display("ERROR: %s", msg);
			fail_count++;
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] echo);
			answer_t a;
			if (predicted_words.size() == 0) begin
				report($sformatf("result word with nothing pending: value %h echo %0d",
					value, echo));
				return;
			end
			a = predicted_words.pop_front();
			if (value !== a.value)
				report($sformatf("random_value %h, expected %h (request %s)",
					value, a.value, a.req.name()));
			if (echo !== a.req)
				report($sformatf("request_echo %0d, expected %0d", echo, a.req));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block's ports. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // seed_value
	logic [1:0]  s_axis_tuser  = '0;   // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // random_value
	logic [1:0]  m_axis_tuser;         // request_echo

	rng_scoreboard sb = new();

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tausworthe_random_table_unit #(
		.TABLE_DEPTH(TableDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// ------------------------------------------------------------------------
	// Monitor. Both handshakes are sampled at the rising edge, where the
	// values seen are the ones the block itself saw. The request word is
	// noted before the result word is checked, so a result that leaves in
	// the same cycle as its own request would still find its expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(req_kind_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// ------------------------------------------------------------------------
	// Result side back-pressure. The pattern is picked at random and held for
	// a random stretch, so that stalls hit results of every kind, including
	// the zero result of a refill. One of the patterns never stalls.
	// ------------------------------------------------------------------------
	typedef enum int {
		ALWAYS_READY,
		COIN_FLIP,
		ONE_IN_FOUR,
		MOSTLY_READY
	} stall_pattern_t;

	stall_pattern_t stall_pattern = ALWAYS_READY;
	int             pattern_left  = 0;

	always @(negedge clk) begin
		if (pattern_left == 0) begin
			stall_pattern = stall_pattern_t'($urandom_range(3));
			pattern_left  = $urandom_range(200, 32);
		end
		pattern_left--;
		case (stall_pattern)
		ALWAYS_READY: m_axis_tready <= 1'b1;
		COIN_FLIP:    m_axis_tready <= 1'($urandom_range(1));
		ONE_IN_FOUR:  m_axis_tready <= (pattern_left % 4 == 0);
		default:      m_axis_tready <= ($urandom_range(99) < 85);
		endcase
	end

	// ------------------------------------------------------------------------
	// Request side. Words go out in bursts of random length. Before a new
	// burst starts there may be a gap of idle cycles, or none at all.
	// tvalid is only changed at the falling edge, and it is never lowered
	// and raised again in the same step.
	// ------------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_request(req_kind_t req, logic [31:0] seed);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if ($urandom_range(9) >= 3)
				gap = $urandom_range(8, 1);
		end
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= seed;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// Picks a request kind by weight. Seed words are often small, so that
	// the node mixing is used a lot, and sometimes lie near the limit at 127.
	// The data field is random for the other kinds too; the block ignores it.
	task automatic send_random_request(int refill_pct, int seed_pct, int produce_pct);
		int          r;
		req_kind_t   req;
		logic [31:0] seed;
		r = $urandom_range(99);
		if (r < refill_pct)
			req = REQ_REFILL;
		else if (r < refill_pct + seed_pct)
			req = REQ_SEED;
		else if (r < refill_pct + seed_pct + produce_pct)
			req = REQ_PRODUCE;
		else
			req = REQ_FAST_READ;
		case ($urandom_range(5))
		0, 1:    seed = $urandom_range(126);
		2:       seed = $urandom_range(131, 123);
		default: seed = $urandom;
		endcase
		send_request(req, seed);
	endtask

	// Drops tvalid and waits until every owed result has come back. A refill
	// hands back its result before it walks the table, so the wait afterwards
	// covers a whole table walk; after it nothing is left in the block.
	task automatic finish_phase();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.predicted_words.size() != 0)
			@(posedge clk);
		repeat (TableDepth + 8) @(posedge clk);
	endtask

	// The node number register is written for one rising edge, while idle.
	task automatic write_node(logic [15:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		sb.node = value;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with the largest node number. Fast reads before any
		// refill must return the cleared table. The seeds cover the smallest
		// value, both sides of the small-seed limit and the all-ones word.
		write_node(16'hFFFF);
		send_request(REQ_FAST_READ, 32'h0000_0000);
		send_request(REQ_FAST_READ, 32'hFFFF_FFFF);
		send_request(REQ_PRODUCE,   32'h0000_0000);
		send_request(REQ_SEED,      32'h0000_0000);
		send_request(REQ_PRODUCE,   32'hFFFF_FFFF);
		send_request(REQ_SEED,      32'd126);
		send_request(REQ_PRODUCE,   32'h0000_0000);
		send_request(REQ_SEED,      32'd127);
		send_request(REQ_PRODUCE,   32'h0000_0000);
		send_request(REQ_SEED,      32'hFFFF_FFFF);
		send_request(REQ_PRODUCE,   32'hAAAA_AAAA);
		send_request(REQ_SEED,      32'h5555_5555);
		send_request(REQ_REFILL,    32'hAAAA_AAAA);
		send_request(REQ_FAST_READ, 32'h0000_0000);
		send_request(REQ_FAST_READ, 32'h0000_0000);
		send_request(REQ_FAST_READ, 32'h0000_0000);
		send_request(REQ_PRODUCE,   32'h0000_0000);
		send_request(REQ_REFILL,    32'h0000_0000);
		send_request(REQ_FAST_READ, 32'hFFFF_FFFF);
		send_request(REQ_SEED,      32'd0);
		finish_phase();

		// Random mix with a random node number, refills included.
		write_node(16'($urandom_range(65535)));
		repeat (300) send_random_request(4, 12, 34);
		finish_phase();

		// Node number zero. One refill, then a long run that is mostly fast
		// reads with no refill in between, so the read index wraps past the
		// end of the table at least once.
		write_node(16'd0);
		send_request(REQ_REFILL, $urandom);
		repeat (680) send_random_request(0, 5, 15);
		finish_phase();

		// Node number one, random mix again.
		write_node(16'd1);
		repeat (350) send_random_request(4, 12, 34);
		finish_phase();

		if (sb.predicted_words.size() != 0)
			sb.report($sformatf("%0d result words never arrived",
				sb.predicted_words.size()));
		if (sb.fail_count == 0) begin
			$display("tausworthe_random_table_unit regression: pass");
		end else begin
			$display("tausworthe_random_table_unit regression: fail");
		end
		$finish;
	end

	// The run is far shorter than this; reaching it means the block hung.
	initial begin
		#8_000_000;
		$display("tausworthe_random_table_unit regression: fail");
		$finish;
	end

endmodule
